FILE: hw/rtl/pba_pkg.sv
package pba_pkg;

  localparam int unsigned POOL_SLOTS_DEF = 16;
  localparam int unsigned POOL_BYTES_DEF = 65536;

  localparam int unsigned ADDR_W = 20;
  localparam int unsigned SIZE_W = 16;
  localparam int unsigned CNT_W  = 16;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SLOT   = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_ILLEGAL   = 2'd3
  } status_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } command_e;

  typedef struct packed {
    logic [CNT_W-1:0] free_bytes;
    logic [CNT_W-1:0] links;
  } slot_entry_t;

endpackage

FILE: hw/rtl/pba_if.sv
interface pba_req_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [pba_pkg::SIZE_W-1:0]  request_size;
  logic [pba_pkg::ADDR_W-1:0]  release_address;

  modport source (output valid, command, request_size, release_address, input ready);
  modport sink   (input valid, command, request_size, release_address, output ready);
endinterface

interface pba_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [pba_pkg::ADDR_W-1:0]  granted_address;
  logic                        pool_released;

  modport source (output valid, status, granted_address, pool_released, input ready);
  modport sink   (input valid, status, granted_address, pool_released, output ready);
endinterface

FILE: hw/rtl/pba_slot_table.sv
module pba_slot_table #(
  parameter int unsigned POOL_SLOTS = pba_pkg::POOL_SLOTS_DEF,
  localparam int unsigned SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [SW-1:0]        rd_addr_i,
  output pba_pkg::slot_entry_t rd_data_o,
  input  logic                 wr_en_i,
  input  logic [SW-1:0]        wr_addr_i,
  input  pba_pkg::slot_entry_t wr_data_i,
  input  logic                 use_set_i,
  input  logic                 use_clr_i,
  input  logic [SW-1:0]        use_addr_i,
  output logic [POOL_SLOTS-1:0] in_use_o
);

  pba_pkg::slot_entry_t  mem [POOL_SLOTS];
  logic [POOL_SLOTS-1:0] in_use_q;

  // Free byte count and link count of each slot; only read after the slot opened.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
    end else if (use_set_i) begin
      in_use_q[use_addr_i] <= 1'b1;
    end else if (use_clr_i) begin
      in_use_q[use_addr_i] <= 1'b0;
    end
  end

  assign in_use_o = in_use_q;

endmodule

FILE: hw/rtl/pool_bump_allocator.sv
// Channel  Dir  Word contents                                  Handshake
// req_i    in   command, request_size, release_address         valid/ready
// rsp_o    out  status, granted_address, pool_released         valid/ready
//
// One request is worked at a time; req_i.ready is high only when the sequencer is idle.
// Allocate: the sequencer walks the creation-order list, one entry per cycle through two
// registered reads, while a search for the lowest unused slot runs alongside.
// Free: decode the slot, update its link count and, when the pool is released,
// compact the list.
// Reset clears the in-use bits and the live pool count; no clearing pass is needed.
// A finished word waits in the output register while the next request is accepted.
module pool_bump_allocator #(
  parameter int unsigned POOL_SLOTS = pba_pkg::POOL_SLOTS_DEF,
  parameter int unsigned POOL_BYTES = pba_pkg::POOL_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pba_req_if.sink    req_i,
  pba_rsp_if.source  rsp_o
);

  localparam int unsigned SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int unsigned CW = $clog2(POOL_SLOTS + 1);
  localparam int unsigned PW = SW + 20;
  localparam int unsigned AW = pba_pkg::ADDR_W;
  localparam int unsigned CNW = pba_pkg::CNT_W;
  localparam logic [SW-1:0] LAST_SLOT = SW'(POOL_SLOTS - 1);
  localparam logic [16:0]   PB17 = 17'(POOL_BYTES);
  localparam logic [PW-1:0] PBW  = PW'(POOL_BYTES);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_WALK   = 4'd1;
  localparam logic [3:0] S_OPEN   = 4'd2;
  localparam logic [3:0] S_FDEC   = 4'd3;
  localparam logic [3:0] S_FRD    = 4'd4;
  localparam logic [3:0] S_FUPD   = 4'd5;
  localparam logic [3:0] S_FFIND  = 4'd6;
  localparam logic [3:0] S_FSHIFT = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0]    state_q, state_d;
  logic [16:0]   size_q, size_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [CW-1:0] live_q, live_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic          p1_q, p1_d;
  logic [CW-1:0] p1_idx_q, p1_idx_d;
  logic          p2_q, p2_d;
  logic [SW-1:0] sel_q, sel_d;
  logic [SW-1:0] scan_k_q, scan_k_d;
  logic          scan_done_q, scan_done_d;
  logic          scan_hit_q, scan_hit_d;
  logic [PW-1:0] hi_q, hi_d;

  pba_pkg::status_e res_status_q, res_status_d;
  logic [AW-1:0]    res_addr_q, res_addr_d;
  logic             res_rel_q, res_rel_d;

  logic          out_valid_q, out_valid_d;
  logic [1:0]    out_status_q;
  logic [AW-1:0] out_addr_q;
  logic          out_rel_q;
  logic          out_load;

  logic [SW-1:0] order_mem [POOL_SLOTS];
  logic [SW-1:0] order_rdata_q;
  logic          order_we;
  logic [SW-1:0] order_waddr;
  logic [SW-1:0] order_wdata;
  logic [SW-1:0] rd_idx_lo;
  logic [SW-1:0] live_lo;
  logic [CW-1:0] shift_dst;

  pba_pkg::slot_entry_t  slot_rdata;
  pba_pkg::slot_entry_t  slot_wdata;
  logic                  slot_we;
  logic [SW-1:0]         slot_waddr;
  logic [SW-1:0]         slot_raddr;
  logic                  use_set;
  logic                  use_clr;
  logic [SW-1:0]         use_addr;
  logic [POOL_SLOTS-1:0] in_use;

  logic          accept;
  logic [16:0]   size_round;
  logic          too_large;
  logic          walking;
  logic          more_to_read;
  logic          walk_hit;
  logic          find_hit;
  logic          issue;
  logic [16:0]   offset;
  logic [SW-1:0] mul_slot;
  logic [PW-1:0] mul_off;
  logic [PW-1:0] grant_full;
  logic [CNW-1:0] new_link;

  pba_slot_table #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_slot_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (slot_raddr),
    .rd_data_o (slot_rdata),
    .wr_en_i   (slot_we),
    .wr_addr_i (slot_waddr),
    .wr_data_i (slot_wdata),
    .use_set_i (use_set),
    .use_clr_i (use_clr),
    .use_addr_i(use_addr),
    .in_use_o  (in_use)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  assign size_round = {1'b0, req_i.request_size} + 17'(req_i.request_size[0]);
  assign too_large  = (size_round >= PB17);

  assign walking      = (state_q == S_WALK) || (state_q == S_FFIND) || (state_q == S_FSHIFT);
  assign more_to_read = (rd_idx_q < live_q);
  assign walk_hit     = (state_q == S_WALK) && p2_q && ({1'b0, slot_rdata.free_bytes} > size_q);
  assign find_hit     = (state_q == S_FFIND) && p1_q && (order_rdata_q == sel_q);
  assign issue        = walking && more_to_read && !walk_hit && !find_hit;

  // The same multiply-add forms the grant for a bump in a live pool and for a new pool.
  assign offset     = PB17 - {1'b0, slot_rdata.free_bytes};
  assign mul_slot   = (state_q == S_OPEN) ? scan_k_q : sel_q;
  assign mul_off    = (state_q == S_OPEN) ? '0 : PW'(offset);
  assign grant_full = PW'(mul_slot) * PBW + mul_off;

  assign new_link   = slot_rdata.links - CNW'(1);
  assign slot_raddr = (state_q == S_WALK) ? order_rdata_q : sel_q;

  assign rd_idx_lo = rd_idx_q[SW-1:0];
  assign live_lo   = live_q[SW-1:0];
  assign shift_dst = p1_idx_q - CW'(1);

  always_ff @(posedge clk_i) begin
    if (order_we) begin
      order_mem[order_waddr] <= order_wdata;
    end
    order_rdata_q <= order_mem[rd_idx_lo];
  end

  always_comb begin
    state_d      = state_q;
    size_d       = size_q;
    addr_d       = addr_q;
    live_d       = live_q;
    rd_idx_d     = rd_idx_q;
    p1_d         = issue;
    p1_idx_d     = rd_idx_q;
    p2_d         = (state_q == S_WALK) && p1_q && !walk_hit;
    sel_d        = sel_q;
    scan_k_d     = scan_k_q;
    scan_done_d  = scan_done_q;
    scan_hit_d   = scan_hit_q;
    hi_d         = hi_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    res_rel_d    = res_rel_q;
    order_we     = 1'b0;
    order_waddr  = live_lo;
    order_wdata  = scan_k_q;
    slot_we      = 1'b0;
    slot_waddr   = sel_q;
    slot_wdata   = slot_rdata;
    use_set      = 1'b0;
    use_clr      = 1'b0;
    use_addr     = sel_q;
    out_load     = 1'b0;

    if (issue) begin
      rd_idx_d = rd_idx_q + CW'(1);
    end
    if ((state_q == S_WALK) && p1_q) begin
      sel_d = order_rdata_q;
    end

    // Search for the lowest unused slot runs alongside the walk.
    if (((state_q == S_WALK) || (state_q == S_OPEN)) && !scan_done_q) begin
      if (!in_use[scan_k_q]) begin
        scan_done_d = 1'b1;
        scan_hit_d  = 1'b1;
      end else if (scan_k_q == LAST_SLOT) begin
        scan_done_d = 1'b1;
      end else begin
        scan_k_d = scan_k_q + SW'(1);
      end
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          addr_d      = req_i.release_address;
          size_d      = size_round;
          rd_idx_d    = '0;
          scan_k_d    = '0;
          scan_done_d = 1'b0;
          scan_hit_d  = 1'b0;
          hi_d        = PBW;
          res_addr_d  = '0;
          res_rel_d   = 1'b0;
          if (req_i.command == pba_pkg::CMD_FREE) begin
            state_d = S_FDEC;
          end else if (too_large) begin
            res_status_d = pba_pkg::ST_TOO_LARGE;
            state_d      = S_DONE;
          end else begin
            state_d = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (walk_hit) begin
          slot_we               = 1'b1;
          slot_wdata.free_bytes = slot_rdata.free_bytes - size_q[CNW-1:0];
          slot_wdata.links      = slot_rdata.links + CNW'(1);
          res_status_d          = pba_pkg::ST_OK;
          res_addr_d            = grant_full[AW-1:0];
          state_d               = S_DONE;
        end else if (!more_to_read && !p1_q && !p2_q) begin
          state_d = S_OPEN;
        end
      end
      S_OPEN: begin
        if (scan_done_q) begin
          if (scan_hit_q) begin
            slot_we               = 1'b1;
            slot_waddr            = scan_k_q;
            slot_wdata.free_bytes = CNW'(PB17 - size_q);
            slot_wdata.links      = CNW'(1);
            use_set               = 1'b1;
            use_addr              = scan_k_q;
            order_we              = 1'b1;
            live_d                = live_q + CW'(1);
            res_status_d          = pba_pkg::ST_OK;
            res_addr_d            = grant_full[AW-1:0];
          end else begin
            res_status_d = pba_pkg::ST_NO_SLOT;
          end
          state_d = S_DONE;
        end
      end
      S_FDEC: begin
        // Slot k covers addresses below hi, which steps by one pool each cycle.
        if (PW'(addr_q) < hi_q) begin
          if (in_use[scan_k_q]) begin
            sel_d   = scan_k_q;
            state_d = S_FRD;
          end else begin
            res_status_d = pba_pkg::ST_ILLEGAL;
            state_d      = S_DONE;
          end
        end else if (scan_k_q == LAST_SLOT) begin
          res_status_d = pba_pkg::ST_ILLEGAL;
          state_d      = S_DONE;
        end else begin
          scan_k_d = scan_k_q + SW'(1);
          hi_d     = hi_q + PBW;
        end
      end
      S_FRD: begin
        state_d = S_FUPD;
      end
      S_FUPD: begin
        slot_we          = 1'b1;
        slot_wdata.links = new_link;
        res_status_d     = pba_pkg::ST_OK;
        if (new_link != '0) begin
          state_d = S_DONE;
        end else begin
          use_clr  = 1'b1;
          rd_idx_d = '0;
          state_d  = S_FFIND;
        end
      end
      S_FFIND: begin
        if (find_hit) begin
          rd_idx_d = p1_idx_q + CW'(1);
          state_d  = S_FSHIFT;
        end
      end
      S_FSHIFT: begin
        // Each later entry moves down by one place.
        if (p1_q) begin
          order_we    = 1'b1;
          order_waddr = shift_dst[SW-1:0];
          order_wdata = order_rdata_q;
        end else if (!more_to_read) begin
          live_d    = live_q - CW'(1);
          res_rel_d = 1'b1;
          state_d   = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !rsp_o.ready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      live_q      <= '0;
      rd_idx_q    <= '0;
      p1_q        <= 1'b0;
      p2_q        <= 1'b0;
      scan_done_q <= 1'b0;
      scan_hit_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      live_q      <= live_d;
      rd_idx_q    <= rd_idx_d;
      p1_q        <= p1_d;
      p2_q        <= p2_d;
      scan_done_q <= scan_done_d;
      scan_hit_q  <= scan_hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q       <= size_d;
    addr_q       <= addr_d;
    p1_idx_q     <= p1_idx_d;
    sel_q        <= sel_d;
    scan_k_q     <= scan_k_d;
    hi_q         <= hi_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    res_rel_q    <= res_rel_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
      out_rel_q    <= res_rel_q;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.status          = out_status_q;
  assign rsp_o.granted_address = out_addr_q;
  assign rsp_o.pool_released   = out_rel_q;

endmodule

FILE: hw/rtl/pba_checker.sv
module pba_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [1:0]                 out_status_i,
  input logic [pba_pkg::ADDR_W-1:0] out_addr_i,
  input logic                       out_rel_i
);

  // A request occupies the sequencer, so ready drops right after a word is taken.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted while a previous one was still in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i)
      && $stable(out_addr_i) && $stable(out_rel_i))
    else $error("stalled result word changed");

  a_fail_is_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != pba_pkg::ST_OK) |-> (out_addr_i == '0) && !out_rel_i)
    else $error("failed request carries an address or a release");

  a_release_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_rel_i |-> (out_addr_i == '0))
    else $error("released pool reported with a granted address");

endmodule

bind pool_bump_allocator pba_checker u_pba_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_status_i(rsp_o.status),
  .out_addr_i  (rsp_o.granted_address),
  .out_rel_i   (rsp_o.pool_released)
);

FILE: sim/pba_checker.sv
`timescale 1ns / 100ps

module pba_tb_checker
  import pba_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  pba_req_if   req_i,
  pba_rsp_if   rsp_i,
  output int   mismatches_o,
  output int   words_due_o
);

  localparam int unsigned SLOTS = POOL_SLOTS_DEF;
  localparam int unsigned BYTES = POOL_BYTES_DEF;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] granted;
    logic              released;
  } pool_word_t;

  logic              live_slot  [SLOTS];
  logic [CNT_W-1:0]  free_bytes [SLOTS];
  logic [CNT_W-1:0]  links      [SLOTS];
  int unsigned       open_order [SLOTS];
  int unsigned       live_pools;

  pool_word_t        due_words [$];
  pool_word_t        oldest;
  int                fail_count;

  function automatic pool_word_t bump_pool_step(command_e cmd, logic [SIZE_W-1:0] size,
                                                logic [ADDR_W-1:0] addr);
    pool_word_t  w;
    int unsigned need;
    int unsigned slot;
    int unsigned pos;
    bit          done;
    w = '{ST_OK, '0, 1'b0};
    done = 1'b0;
    if (cmd == CMD_ALLOC) begin
      need = size + size[0];
      if (need >= BYTES) begin
        w.status = ST_TOO_LARGE;
      end else begin
        // Oldest live pool first; the free count must strictly exceed the size.
        for (pos = 0; pos < live_pools && !done; pos++) begin
          slot = open_order[pos];
          if (free_bytes[slot] > need) begin
            w.granted = ADDR_W'(slot * BYTES + (BYTES - free_bytes[slot]));
            free_bytes[slot] = free_bytes[slot] - CNT_W'(need);
            links[slot] = links[slot] + 1'b1;
            done = 1'b1;
          end
        end
        for (slot = 0; slot < SLOTS && !done; slot++) begin
          if (!live_slot[slot]) begin
            live_slot[slot] = 1'b1;
            links[slot] = CNT_W'(1);
            // A zero-byte request on a full-size pool leaves a free count of zero.
            free_bytes[slot] = CNT_W'(BYTES - need);
            open_order[live_pools] = slot;
            live_pools++;
            w.granted = ADDR_W'(slot * BYTES);
            done = 1'b1;
          end
        end
        if (!done) w.status = ST_NO_SLOT;
      end
    end else begin
      slot = addr / BYTES;
      if (slot >= SLOTS || !live_slot[slot]) begin
        w.status = ST_ILLEGAL;
      end else begin
        links[slot] = links[slot] - 1'b1;
        if (links[slot] == 0) begin
          live_slot[slot] = 1'b0;
          w.released = 1'b1;
          for (pos = 0; pos < live_pools; pos++) begin
            if (done) open_order[pos-1] = open_order[pos];
            else if (open_order[pos] == slot) done = 1'b1;
          end
          if (done) live_pools--;
        end
      end
    end
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SLOTS; k++) begin
        live_slot[k] = 1'b0;
        free_bytes[k] = '0;
        links[k] = '0;
        open_order[k] = 0;
      end
      live_pools = 0;
      fail_count = 0;
      due_words.delete();
      mismatches_o <= 0;
      words_due_o <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (due_words.size() == 0) begin
          $error("unexpected word: status %0d, granted_address 0x%05h, pool_released %0d",
                 rsp_i.status, rsp_i.granted_address, rsp_i.pool_released);
          fail_count++;
        end else begin
          oldest = due_words.pop_front();
          if (rsp_i.status !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, rsp_i.status);
            fail_count++;
          end
          if (rsp_i.granted_address !== oldest.granted) begin
            $error("granted_address: expected 0x%05h, got 0x%05h",
                   oldest.granted, rsp_i.granted_address);
            fail_count++;
          end
          if (rsp_i.pool_released !== oldest.released) begin
            $error("pool_released: expected %0d, got %0d",
                   oldest.released, rsp_i.pool_released);
            fail_count++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        due_words.push_back(bump_pool_step(command_e'(req_i.command), req_i.request_size,
                                           req_i.release_address));
      end
      mismatches_o <= fail_count;
      words_due_o <= due_words.size();
    end
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import pba_pkg::*;

  localparam int RANDOM_WORDS = 600;
  localparam int ZERO_BUMPS   = 3;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 250;
  localparam int DRAIN_CYCLES = 60;
  localparam int GRANT_KEEP   = 64;

  logic              clk_i;
  logic              rst_ni;
  bit                calm;
  bit                keep_grants;
  int                mismatches;
  int                words_due;
  command_e          sent_cmds [$];
  logic [ADDR_W-1:0] grants [$];

  pba_req_if req ();
  pba_rsp_if rsp ();

  pool_bump_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  pba_tb_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .rsp_i        (rsp),
    .mismatches_o (mismatches),
    .words_due_o  (words_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_word(command_e cmd, logic [SIZE_W-1:0] size,
                           logic [ADDR_W-1:0] addr);
    while (!calm && $urandom_range(99) < 20) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.command <= cmd;
    req.request_size <= size;
    req.release_address <= addr;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    sent_cmds.push_back(cmd);
  endtask

  initial begin : stimulus
    int unsigned       pick;
    int unsigned       idx;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    calm = 1'b0;
    keep_grants = 1'b0;
    rst_ni <= 1'b0;
    req.valid <= 1'b0;
    req.command <= CMD_ALLOC;
    req.request_size <= '0;
    req.release_address <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A zero-byte request opens a pool with nothing left, so the next one opens slot 1.
    send_word(CMD_ALLOC, 16'd0, '0);
    send_word(CMD_ALLOC, 16'd0, 20'hFFFFF);
    send_word(CMD_FREE, 16'hFFFF, 20'h10000);
    send_word(CMD_FREE, '0, 20'h10000);
    send_word(CMD_ALLOC, 16'hFFFF, '0);
    send_word(CMD_ALLOC, 16'hFFFD, '0);
    // Slot 1 keeps two bytes, so zero-byte requests bump it and add links without
    // using any bytes.
    calm = 1'b1;
    repeat (ZERO_BUMPS) send_word(CMD_ALLOC, 16'd0, '0);
    send_word(CMD_FREE, '0, 20'h1FFFF);
    send_word(CMD_FREE, '0, 20'h00000);
    calm = 1'b0;
    send_word(CMD_ALLOC, 16'd1, '0);
    send_word(CMD_ALLOC, 16'd40001, '0);
    repeat (14) send_word(CMD_ALLOC, 16'd40000, '0);
    send_word(CMD_ALLOC, 16'd40000, '0);
    send_word(CMD_FREE, '0, 20'hF0000);
    send_word(CMD_FREE, '0, 20'hF0000);

    keep_grants = 1'b1;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      calm = (n >= 250 && n < 350);
      if ($urandom_range(99) < 55) begin
        pick = $urandom_range(99);
        if (pick < 30) size = SIZE_W'($urandom_range(255));
        else if (pick < 55) size = SIZE_W'($urandom_range(4095));
        else if (pick < 80) size = SIZE_W'($urandom_range(32767));
        else if (pick < 95) size = SIZE_W'($urandom_range(65535));
        else size = SIZE_W'(65533 + $urandom_range(2));
        send_word(CMD_ALLOC, size, ADDR_W'($urandom));
      end else begin
        // Most frees return a granted address; some repeat one, others use a random address that may hit no live pool.
        if (grants.size() > 0 && $urandom_range(99) < 80) begin
          idx = $urandom_range(grants.size() - 1);
          addr = grants[idx];
          if ($urandom_range(9) != 0) grants.delete(idx);
        end else begin
          addr = ADDR_W'($urandom);
        end
        send_word(CMD_FREE, SIZE_W'($urandom), addr);
      end
    end
    calm = 1'b0;
    req.valid <= 1'b0;

    @(posedge clk_i);
    while (words_due != 0 || sent_cmds.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin : receiver
    int       hold;
    int       taken;
    command_e cmd;
    hold = 0;
    taken = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp.valid && rsp.ready) begin
        taken++;
        cmd = sent_cmds.pop_front();
        if (keep_grants && cmd == CMD_ALLOC && rsp.status == ST_OK &&
            grants.size() < GRANT_KEEP) begin
          grants.push_back(rsp.granted_address);
        end
        // Hold the output off long enough for the block to back up its input.
        if (taken == HOLD_AFTER) hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= calm || ($urandom_range(99) >= 20);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_top failed");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/pba_pkg.sv
hw/rtl/pba_if.sv
hw/rtl/pba_slot_table.sv
hw/rtl/pool_bump_allocator.sv
hw/rtl/pba_checker.sv
sim/pba_checker.sv
sim/tb_top.sv
